/* hw/rtl/b64_pkg.sv */
package b64_pkg;

   // input beat: one byte or character
   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_in;
   } b64_req_type;

   // result beat
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       stream_end;
      logic [1:0] status;
   } b64_rsp_type;

   // results of one closed group, beat 0 first
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      logic            stream_end;
      logic [1:0]      status;
   } b64_bundle_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_CHAR = 2'd1;
   localparam logic [1:0] ST_BAD_LEN  = 2'd2;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   localparam logic REG_MODE = 1'b0;

   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_PAD     = 8'h3D;

   localparam logic [6:0] SEXTET_INVALID = 7'd64;

   function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
      logic [7:0] w;
      logic [7:0] c;
      w = {2'b00, s};
      if (w < 8'd26) begin
         c = CH_UPPER_A + w;
      end else if (w < 8'd52) begin
         c = CH_LOWER_A + w - 8'd26;
      end else if (w < 8'd62) begin
         c = CH_DIGIT_0 + w - 8'd52;
      end else if (w == 8'd62) begin
         c = CH_PLUS;
      end else begin
         c = CH_SLASH;
      end
      return c;
   endfunction

   // sextet value, or SEXTET_INVALID outside the alphabet
   function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
      logic [7:0] v;
      v = {1'b0, SEXTET_INVALID};
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         v = c - CH_UPPER_A;
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         v = c - CH_LOWER_A + 8'd26;
      end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
         v = c - CH_DIGIT_0 + 8'd52;
      end else if (c == CH_PLUS) begin
         v = 8'd62;
      end else if (c == CH_SLASH) begin
         v = 8'd63;
      end
      return v[6:0];
   endfunction

endpackage

/* hw/rtl/base64_codec_unit.sv */
// the first result beat of a group shows in the cycle after the beat that closes it
// throughput: one input beat per cycle; a beat that closes a group waits only while the
//   previous group still drains, one result beat per cycle while rsp_stall is low
// reset: synchronous, active high; mode returns to encode, stream state and results clear
module base64_codec_unit (
   input  logic                 clock,
   input  logic                 reset,
   // input beats
   input  logic                 req_valid,
   output logic                 req_stall,
   input  b64_pkg::b64_req_type req_data,
   // result beats
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output b64_pkg::b64_rsp_type rsp_data,
   // register port
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   import b64_pkg::*;

   logic           mode_ff, mode_in;
   logic           csr_write;
   logic           mode_write;
   logic           accept;
   logic           has_out;
   logic           free;
   logic           load;
   b64_bundle_type bundle;

   // register port: single mode register, selected when address bit 2 is zero (byte addresses 0 to 3)
   always_comb begin
      csr_pready = 1'b1;
      csr_write  = csr_psel && csr_penable && csr_pwrite;
      mode_write = csr_write && (csr_paddr[2] == REG_MODE);
      mode_in    = mode_write ? csr_pwdata[0] : mode_ff;
      csr_prdata = (csr_paddr[2] == REG_MODE) ? {31'd0, mode_ff} : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ENCODE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // a beat that closes a group needs the result buffer; other beats always pass
   always_comb begin
      req_stall = has_out && !free;
      accept    = req_valid && !req_stall;
      load      = accept && has_out;
   end

   // group assembly and per-group result computation
   b64_group u_group (
      .clock   (clock),
      .reset   (reset),
      .clear   (mode_write),
      .mode    (mode_ff),
      .accept  (accept),
      .req     (req_data),
      .has_out (has_out),
      .bundle  (bundle)
   );

   // result buffer, drains one beat per cycle while rsp_stall is low
   b64_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .bundle    (bundle),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // input is only held back while results are pending
   a_stall_needs_pending: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no pending result");

   // end of stream always closes a run
   a_stream_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.stream_end) |-> rsp_data.last_of_run)
      else $error("stream end without last of run");

   // error results are single beats at the end of a decode stream
   a_error_is_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |->
         (rsp_data.stream_end && mode_ff == MODE_DECODE))
      else $error("error result not at decode stream end");

   // a beat that closes a group lands in the buffer on the next cycle
   a_load_shows_result: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("closed group produced no result");
`endif

endmodule

/* hw/rtl/b64_group.sv */
module b64_group (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear,
   input  logic                   mode,
   input  logic                   accept,
   input  b64_pkg::b64_req_type   req,
   output logic                   has_out,
   output b64_pkg::b64_bundle_type bundle
);
   import b64_pkg::*;

   logic [23:0] group_bits_ff, group_bits_in;
   logic [1:0]  group_count_ff, group_count_in;
   logic [1:0]  pad_marks_ff, pad_marks_in;
   logic        bad_seen_ff, bad_seen_in;

   // encode side
   logic [2:0]  enc_cnt;
   logic [23:0] enc_bits;
   logic [23:0] enc_triple;
   logic [1:0]  enc_pads;
   logic        enc_close;

   // decode side
   logic        is_pad;
   logic [6:0]  dec_sextet;
   logic        dec_bad_now;
   logic [5:0]  dec_v;
   logic [23:0] dec_bits;
   logic [1:0]  dec_pads;
   logic        dec_bad;

   always_comb begin
      enc_cnt   = {1'b0, group_count_ff} + 3'd1;
      enc_bits  = {group_bits_ff[15:0], req.in_byte};
      enc_close = (enc_cnt >= 3'd3) || req.last_in;
      case (enc_cnt)
         3'd1: begin
            enc_triple = {enc_bits[7:0], 16'h0000};
            enc_pads   = 2'd2;
         end
         3'd2: begin
            enc_triple = {enc_bits[15:0], 8'h00};
            enc_pads   = 2'd1;
         end
         default: begin
            enc_triple = enc_bits;
            enc_pads   = 2'd0;
         end
      endcase

      is_pad      = (req.in_byte == CH_PAD);
      dec_sextet  = char_to_sextet(req.in_byte);
      dec_bad_now = !is_pad && (dec_sextet == SEXTET_INVALID);
      dec_v       = (is_pad || dec_bad_now) ? 6'd0 : dec_sextet[5:0];
      dec_bits    = {group_bits_ff[17:0], dec_v};
      dec_pads    = (is_pad && group_count_ff[1]) ? pad_marks_ff + 2'd1 : pad_marks_ff;
      dec_bad     = bad_seen_ff || dec_bad_now;
   end

   always_comb begin
      has_out           = 1'b0;
      bundle.bytes      = '0;
      bundle.last_idx   = 2'd0;
      bundle.stream_end = req.last_in;
      bundle.status     = ST_OK;
      group_bits_in     = group_bits_ff;
      group_count_in    = group_count_ff;
      pad_marks_in      = pad_marks_ff;
      bad_seen_in       = bad_seen_ff;

      if (mode == MODE_ENCODE) begin
         if (enc_close) begin
            has_out         = 1'b1;
            bundle.last_idx = 2'd3;
            for (int k = 0; k < 4; k++) begin
               bundle.bytes[k] = sextet_to_char(enc_triple[23 - 6*k -: 6]);
            end
            if (enc_pads == 2'd2) begin
               bundle.bytes[2] = CH_PAD;
            end
            if (enc_pads != 2'd0) begin
               bundle.bytes[3] = CH_PAD;
            end
            group_bits_in  = '0;
            group_count_in = '0;
         end else begin
            group_bits_in  = enc_bits;
            group_count_in = enc_cnt[1:0];
         end
      end else begin
         bundle.bytes[0] = dec_bits[23:16];
         bundle.bytes[1] = dec_bits[15:8];
         bundle.bytes[2] = dec_bits[7:0];
         if (req.last_in) begin
            has_out = 1'b1;
            if (dec_bad) begin
               bundle.bytes  = '0;
               bundle.status = ST_BAD_CHAR;
            end else if (group_count_ff != 2'd3) begin
               bundle.bytes  = '0;
               bundle.status = ST_BAD_LEN;
            end else begin
               case (dec_pads)
                  2'd0:    bundle.last_idx = 2'd2;
                  2'd1:    bundle.last_idx = 2'd1;
                  default: bundle.last_idx = 2'd0;
               endcase
            end
         end else if (group_count_ff == 2'd3) begin
            has_out         = 1'b1;
            bundle.last_idx = 2'd2;
            group_bits_in   = '0;
            group_count_in  = '0;
            pad_marks_in    = '0;
            bad_seen_in     = dec_bad;
         end else begin
            group_bits_in  = dec_bits;
            group_count_in = group_count_ff + 2'd1;
            pad_marks_in   = dec_pads;
            bad_seen_in    = dec_bad;
         end
      end

      // end of stream returns everything to zero
      if (req.last_in) begin
         group_bits_in  = '0;
         group_count_in = '0;
         pad_marks_in   = '0;
         bad_seen_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         group_bits_ff  <= '0;
         group_count_ff <= '0;
         pad_marks_ff   <= '0;
         bad_seen_ff    <= 1'b0;
      end else if (accept) begin
         group_bits_ff  <= group_bits_in;
         group_count_ff <= group_count_in;
         pad_marks_ff   <= pad_marks_in;
         bad_seen_ff    <= bad_seen_in;
      end
   end

endmodule

/* hw/rtl/b64_serializer.sv */
module b64_serializer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  b64_pkg::b64_bundle_type bundle,
   output logic                    free,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output b64_pkg::b64_rsp_type    rsp_data
);
   import b64_pkg::*;

   b64_bundle_type pend_ff, pend_in;
   logic           valid_ff, valid_in;
   logic [1:0]     idx_ff, idx_in;
   logic           take;
   logic           done;

   always_comb begin
      take = valid_ff && !rsp_stall;
      done = take && (idx_ff == pend_ff.last_idx);
      free = !valid_ff || done;

      pend_in  = pend_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         pend_in  = bundle;
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end

      rsp_valid            = valid_ff;
      rsp_data.out_byte    = pend_ff.bytes[idx_ff];
      rsp_data.last_of_run = (idx_ff == pend_ff.last_idx);
      rsp_data.stream_end  = (idx_ff == pend_ff.last_idx) && pend_ff.stream_end;
      rsp_data.status      = pend_ff.status;
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

endmodule
